@@ hw/rtl/ogcq_pkg.sv @@
// Shared constants, codes and controller/datapath interface types for the clearance query.
package ogcq_pkg;

    localparam int MAX_COLUMNS = 64;
    localparam int MAX_ROWS    = 64;
    localparam int COL_W       = $clog2(MAX_COLUMNS);
    localparam int ROW_W       = $clog2(MAX_ROWS);
    localparam int MAP_DEPTH   = MAX_COLUMNS * MAX_ROWS;
    localparam int MAP_AW      = COL_W + ROW_W;
    localparam int CRD_W       = 24;
    localparam int CS_W        = 16;
    localparam int DIM_W       = 7;
    localparam int WIDE_W      = 28;   // signed working width for positions
    localparam int NUM_W       = 22;   // offset inside the grid, below 64 * cell size
    localparam int MAG_W       = 17;   // distance saturated just above the largest radius
    localparam int SQ_W        = 2 * MAG_W;
    localparam int R2_W        = 2 * CS_W;
    localparam int CFG_AW      = 3;
    localparam int NUM_DIV     = 6;

    localparam logic [1:0] MODE_WRITE  = 2'd0;
    localparam logic [1:0] MODE_POINT  = 2'd1;
    localparam logic [1:0] MODE_CIRCLE = 2'd2;
    localparam logic [1:0] MODE_RSVD   = 2'd3;

    localparam logic [CFG_AW-1:0] REG_ORIGIN_X  = 3'd0;
    localparam logic [CFG_AW-1:0] REG_ORIGIN_Y  = 3'd1;
    localparam logic [CFG_AW-1:0] REG_CELL_SIZE = 3'd2;
    localparam logic [CFG_AW-1:0] REG_GRID_W    = 3'd3;
    localparam logic [CFG_AW-1:0] REG_GRID_H    = 3'd4;

    // divide slots: centre x/y, box low x/y, box high x/y
    localparam logic [2:0] DIV_CX = 3'd0;
    localparam logic [2:0] DIV_CY = 3'd1;
    localparam logic [2:0] DIV_X0 = 3'd2;
    localparam logic [2:0] DIV_Y0 = 3'd3;
    localparam logic [2:0] DIV_X1 = 3'd4;
    localparam logic [2:0] DIV_Y1 = 3'd5;
    localparam logic [2:0] DIV_TOP_BIT = 3'(COL_W - 1);

    typedef struct packed {
        logic       clr_we;
        logic       map_we;
        logic       load;
        logic       prep;
        logic       div_load;
        logic       div_step;
        logic [2:0] div_sel;
        logic [2:0] div_bit;
        logic       found;
        logic       pt_rd;
        logic       pt_chk;
        logic       row0;
        logic       row1;
        logic       cell0;
        logic       cell1;
        logic       cell2;
    } ogcq_cmd_t;

    typedef struct packed {
        logic       clr_last;
        logic       x_last;
        logic       y_last;
        logic [1:0] mode;
    } ogcq_sts_t;

    // distance from p to the span [co, co + cs - 1], saturated to MAG_W bits
    function automatic logic [MAG_W-1:0] span_dist(input logic signed [WIDE_W-1:0] p,
                                                   input logic signed [WIDE_W-1:0] co,
                                                   input logic [CS_W-1:0] cs);
        logic signed [WIDE_W-1:0] hi;
        logic signed [WIDE_W-1:0] d;
        hi = co + WIDE_W'(cs) - WIDE_W'(1);
        if (p < co)
            d = co - p;
        else if (p > hi)
            d = p - hi;
        else
            d = '0;
        if (d[WIDE_W-1:CS_W] != '0)
            return {1'b1, {CS_W{1'b0}}};
        return {1'b0, d[CS_W-1:0]};
    endfunction

endpackage

@@ hw/rtl/ogcq_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
module ogcq_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ hw/rtl/ogcq_ctrl.sv @@
// Sequencer for map clearing, the shared divider and the cell walk.
module ogcq_ctrl import ogcq_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  logic [1:0] mode,
    input  ogcq_sts_t sts,
    output ogcq_cmd_t cmd,
    output logic      busy,
    output logic      done
);

    localparam logic [3:0] S_CLEAR  = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_PREP   = 4'd2;
    localparam logic [3:0] S_DLOAD  = 4'd3;
    localparam logic [3:0] S_DSTEP  = 4'd4;
    localparam logic [3:0] S_FOUND  = 4'd5;
    localparam logic [3:0] S_PT_RD  = 4'd6;
    localparam logic [3:0] S_PT_CHK = 4'd7;
    localparam logic [3:0] S_ROW0   = 4'd8;
    localparam logic [3:0] S_ROW1   = 4'd9;
    localparam logic [3:0] S_CELL0  = 4'd10;
    localparam logic [3:0] S_CELL1  = 4'd11;
    localparam logic [3:0] S_CELL2  = 4'd12;
    localparam logic [3:0] S_DONE   = 4'd13;

    logic [3:0] state_reg, state_next;
    logic [2:0] sel_reg, sel_next;
    logic [2:0] bit_reg, bit_next;
    logic       pt_mode;

    assign pt_mode = (sts.mode == MODE_POINT);

    always_comb
    begin
        state_next  = state_reg;
        sel_next    = sel_reg;
        bit_next    = bit_reg;
        cmd         = '0;
        cmd.div_sel = sel_reg;
        cmd.div_bit = bit_reg;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_we = 1'b1;
                if (sts.clr_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    cmd.map_we = (mode == MODE_WRITE);
                    if (mode == MODE_POINT || mode == MODE_CIRCLE)
                        state_next = S_PREP;
                    else
                        state_next = S_DONE;
                end
            end
            S_PREP:
            begin
                cmd.prep   = 1'b1;
                sel_next   = DIV_CX;
                state_next = S_DLOAD;
            end
            S_DLOAD:
            begin
                cmd.div_load = 1'b1;
                bit_next     = DIV_TOP_BIT;
                state_next   = S_DSTEP;
            end
            S_DSTEP:
            begin
                cmd.div_step = 1'b1;
                if (bit_reg == 3'd0)
                begin
                    if ((pt_mode && sel_reg == DIV_CY) || sel_reg == DIV_Y1)
                        state_next = S_FOUND;
                    else
                    begin
                        sel_next   = sel_reg + 3'd1;
                        state_next = S_DLOAD;
                    end
                end
                else
                    bit_next = bit_reg - 3'd1;
            end
            S_FOUND:
            begin
                cmd.found  = 1'b1;
                state_next = pt_mode ? S_PT_RD : S_ROW0;
            end
            S_PT_RD:
            begin
                cmd.pt_rd  = 1'b1;
                state_next = S_PT_CHK;
            end
            S_PT_CHK:
            begin
                cmd.pt_chk = 1'b1;
                state_next = S_DONE;
            end
            S_ROW0:
            begin
                cmd.row0   = 1'b1;
                state_next = S_ROW1;
            end
            S_ROW1:
            begin
                cmd.row1   = 1'b1;
                state_next = S_CELL0;
            end
            S_CELL0:
            begin
                cmd.cell0  = 1'b1;
                state_next = S_CELL1;
            end
            S_CELL1:
            begin
                cmd.cell1  = 1'b1;
                state_next = S_CELL2;
            end
            S_CELL2:
            begin
                cmd.cell2 = 1'b1;
                if (!sts.x_last)
                    state_next = S_CELL0;
                else if (!sts.y_last)
                    state_next = S_ROW0;
                else
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            sel_reg   <= '0;
            bit_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            sel_reg   <= sel_next;
            bit_reg   <= bit_next;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_DONE);

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n) done |=> !done)
        else $error("result strobe longer than one cycle");
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction did not raise busy");
    a_sel_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DSTEP) |-> (sel_reg <= DIV_Y1))
        else $error("divide slot out of range");
    a_no_done_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |=> !done)
        else $error("result during map clear");

endmodule

@@ hw/rtl/ogcq_dp.sv @@
// Datapath: configuration, occupancy map, shared divider and cell distance test.
module ogcq_dp import ogcq_pkg::*; (
    input  logic                     clk,
    input  logic                     rst_n,
    input  ogcq_cmd_t                cmd,
    output ogcq_sts_t                sts,
    input  logic                     cfg_wr_en,
    input  logic [CFG_AW-1:0]        cfg_addr,
    input  logic [CRD_W-1:0]         cfg_wdata,
    input  logic [1:0]               mode,
    input  logic [COL_W-1:0]         write_x,
    input  logic [ROW_W-1:0]         write_y,
    input  logic                     occupied,
    input  logic signed [CRD_W-1:0]  pos_x,
    input  logic signed [CRD_W-1:0]  pos_y,
    input  logic [CS_W-1:0]          radius,
    output logic                     position_free,
    output logic                     inside_grid,
    output logic [COL_W-1:0]         found_x,
    output logic [ROW_W-1:0]         found_y
);

    logic signed [CRD_W-1:0]  ox_reg, oy_reg;
    logic [CS_W-1:0]          cs_reg;
    logic [DIM_W-1:0]         gw_reg, gh_reg;

    logic [1:0]               mode_reg;
    logic signed [CRD_W-1:0]  px_reg, py_reg;
    logic [CS_W-1:0]          r_reg;

    logic signed [WIDE_W-1:0] endx_reg, endy_reg;
    logic [R2_W-1:0]          r2_reg;
    logic [NUM_W-1:0]         rem_reg;
    logic [COL_W-1:0]         q_reg [NUM_DIV];
    logic [COL_W-1:0]         x_reg;
    logic [ROW_W-1:0]         y_reg;
    logic signed [WIDE_W-1:0] coy_reg, cox_reg;
    logic [SQ_W-1:0]          dysq_reg, dxsq_reg;
    logic                     any_reg, blocked_reg;
    logic [MAP_AW-1:0]        clr_reg;

    logic                     pfree_reg, inside_reg;
    logic [COL_W-1:0]         fx_reg;
    logic [ROW_W-1:0]         fy_reg;

    logic [CS_W-1:0]          cs_eff;
    logic [DIM_W-1:0]         w_eff, h_eff;
    logic signed [WIDE_W-1:0] oxe, oye, pxe, pye, re;
    logic signed [WIDE_W-1:0] dv, dlo, dhi, dcl, doff;
    logic [NUM_W:0]           dvs, trial;
    logic [MAG_W-1:0]         dy_mag, dx_mag;
    logic [SQ_W:0]            dsum;
    logic                     hit;

    logic                     ram_we, ram_re, ram_wd, ram_rd;
    logic [MAP_AW-1:0]        ram_wa, ram_ra;

    assign cs_eff = (cs_reg == '0) ? CS_W'(1) : cs_reg;
    assign w_eff  = (gw_reg == '0) ? DIM_W'(1) :
                    (gw_reg > DIM_W'(MAX_COLUMNS)) ? DIM_W'(MAX_COLUMNS) : gw_reg;
    assign h_eff  = (gh_reg == '0) ? DIM_W'(1) :
                    (gh_reg > DIM_W'(MAX_ROWS)) ? DIM_W'(MAX_ROWS) : gh_reg;

    assign oxe = WIDE_W'(ox_reg);
    assign oye = WIDE_W'(oy_reg);
    assign pxe = WIDE_W'(px_reg);
    assign pye = WIDE_W'(py_reg);
    assign re  = WIDE_W'({1'b0, r_reg});

    // clamp the selected coordinate into the grid, then offset from the origin
    always_comb
    begin
        case (cmd.div_sel)
            DIV_CX:  dv = pxe;
            DIV_CY:  dv = pye;
            DIV_X0:  dv = pxe - re;
            DIV_Y0:  dv = pye - re;
            DIV_X1:  dv = pxe + re;
            DIV_Y1:  dv = pye + re;
            default: dv = pxe;
        endcase
        dlo = cmd.div_sel[0] ? oye : oxe;
        dhi = (cmd.div_sel[0] ? endy_reg : endx_reg) - WIDE_W'(1);
        if (dv < dlo)
            dcl = dlo;
        else if (dv > dhi)
            dcl = dhi;
        else
            dcl = dv;
        doff = dcl - dlo;
    end

    assign dvs   = (NUM_W+1)'(cs_eff) << cmd.div_bit;
    assign trial = {1'b0, rem_reg} - dvs;

    assign dy_mag = span_dist(pye, coy_reg, cs_eff);
    assign dx_mag = span_dist(pxe, cox_reg, cs_eff);
    assign dsum   = {1'b0, dxsq_reg} + {1'b0, dysq_reg};
    assign hit    = dsum < (SQ_W+1)'(r2_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ox_reg <= '0;
            oy_reg <= '0;
            cs_reg <= CS_W'(256);
            gw_reg <= DIM_W'(MAX_COLUMNS);
            gh_reg <= DIM_W'(MAX_ROWS);
        end
        else if (cfg_wr_en)
        begin
            case (cfg_addr)
                REG_ORIGIN_X:  ox_reg <= cfg_wdata;
                REG_ORIGIN_Y:  oy_reg <= cfg_wdata;
                REG_CELL_SIZE: cs_reg <= cfg_wdata[CS_W-1:0];
                REG_GRID_W:    gw_reg <= cfg_wdata[DIM_W-1:0];
                REG_GRID_H:    gh_reg <= cfg_wdata[DIM_W-1:0];
                default:       ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clr_reg <= '0;
        else if (cmd.clr_we)
            clr_reg <= clr_reg + MAP_AW'(1);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg    <= mode;
            px_reg      <= pos_x;
            py_reg      <= pos_y;
            r_reg       <= radius;
            pfree_reg   <= 1'b0;
            inside_reg  <= 1'b0;
            fx_reg      <= '0;
            fy_reg      <= '0;
            any_reg     <= 1'b0;
            blocked_reg <= 1'b0;
        end
        if (cmd.prep)
        begin
            endx_reg <= oxe + WIDE_W'(w_eff * cs_eff);
            endy_reg <= oye + WIDE_W'(h_eff * cs_eff);
            r2_reg   <= r_reg * r_reg;
        end
        if (cmd.div_load)
        begin
            rem_reg              <= doff[NUM_W-1:0];
            q_reg[cmd.div_sel]   <= '0;
        end
        if (cmd.div_step && !trial[NUM_W])
        begin
            rem_reg                         <= trial[NUM_W-1:0];
            q_reg[cmd.div_sel][cmd.div_bit] <= 1'b1;
        end
        if (cmd.found)
        begin
            inside_reg <= (pxe >= oxe) && (pye >= oye) && (pxe < endx_reg) && (pye < endy_reg);
            if ((pxe >= oxe) && (pye >= oye) && (pxe < endx_reg) && (pye < endy_reg))
            begin
                fx_reg <= q_reg[DIV_CX];
                fy_reg <= q_reg[DIV_CY];
            end
            y_reg <= q_reg[DIV_Y0];
        end
        if (cmd.pt_chk)
            pfree_reg <= inside_reg && !ram_rd;
        if (cmd.row0)
        begin
            coy_reg <= oye + WIDE_W'(y_reg * cs_eff);
            x_reg   <= q_reg[DIV_X0];
        end
        if (cmd.row1)
            dysq_reg <= dy_mag * dy_mag;
        if (cmd.cell0)
            cox_reg <= oxe + WIDE_W'(x_reg * cs_eff);
        if (cmd.cell1)
            dxsq_reg <= dx_mag * dx_mag;
        if (cmd.cell2)
        begin
            any_reg     <= any_reg || hit;
            blocked_reg <= blocked_reg || (hit && ram_rd);
            pfree_reg   <= (any_reg || hit) && !(blocked_reg || (hit && ram_rd));
            if (x_reg != q_reg[DIV_X1])
                x_reg <= x_reg + COL_W'(1);
            else if (y_reg != q_reg[DIV_Y1])
                y_reg <= y_reg + ROW_W'(1);
        end
    end

    assign ram_we = cmd.clr_we || cmd.map_we;
    assign ram_wa = cmd.clr_we ? clr_reg : {write_y, write_x};
    assign ram_wd = cmd.clr_we ? 1'b0 : occupied;
    assign ram_re = cmd.pt_rd || cmd.cell0;
    assign ram_ra = cmd.pt_rd ? {q_reg[DIV_CY], q_reg[DIV_CX]} : {y_reg, x_reg};

    ogcq_ram #(
        .WIDTH (1),
        .DEPTH (MAP_DEPTH)
    ) u_map (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_wa),
        .wdata (ram_wd),
        .re    (ram_re),
        .raddr (ram_ra),
        .rdata (ram_rd)
    );

    assign sts.clr_last = (clr_reg == MAP_AW'(MAP_DEPTH - 1));
    assign sts.x_last   = (x_reg == q_reg[DIV_X1]);
    assign sts.y_last   = (y_reg == q_reg[DIV_Y1]);
    assign sts.mode     = mode_reg;

    assign position_free = pfree_reg;
    assign inside_grid   = inside_reg;
    assign found_x       = fx_reg;
    assign found_y       = fy_reg;

endmodule

@@ hw/rtl/occupancy_grid_clearance_query.sv @@
// Top level of the occupancy grid clearance query.
// After reset the block clears its 4096-cell map, one cell a cycle, holding busy high until
// the clear is done; configuration writes are taken during that time. A transaction is accepted
// when start is high and busy is low, and its result appears for exactly one cycle with
// done high; the receiver cannot stall it. A point query runs two 6-step divides on the
// shared restoring divider. A circle query runs six divides and then walks its clamped
// bounding box: per row a row origin multiply and a distance square, per cell the chain of
// cell origin multiply, distance square and compare.
module occupancy_grid_clearance_query import ogcq_pkg::*; (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    output logic                     done,
    input  logic                     cfg_wr_en,
    input  logic [CFG_AW-1:0]        cfg_addr,
    input  logic [CRD_W-1:0]         cfg_wdata,
    input  logic [1:0]               mode,
    input  logic [COL_W-1:0]         write_x,
    input  logic [ROW_W-1:0]         write_y,
    input  logic                     occupied,
    input  logic signed [CRD_W-1:0]  pos_x,
    input  logic signed [CRD_W-1:0]  pos_y,
    input  logic [CS_W-1:0]          radius,
    output logic                     position_free,
    output logic                     inside_grid,
    output logic [COL_W-1:0]         found_x,
    output logic [ROW_W-1:0]         found_y
);

    ogcq_cmd_t cmd;
    ogcq_sts_t sts;

    ogcq_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .mode  (mode),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    ogcq_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .mode          (mode),
        .write_x       (write_x),
        .write_y       (write_y),
        .occupied      (occupied),
        .pos_x         (pos_x),
        .pos_y         (pos_y),
        .radius        (radius),
        .position_free (position_free),
        .inside_grid   (inside_grid),
        .found_x       (found_x),
        .found_y       (found_y)
    );

endmodule

@@ sim/occupancy_grid_clearance_query_tb.sv @@
// Self-checking testbench for the occupancy grid clearance query block.
module occupancy_grid_clearance_query_tb import ogcq_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint CYCLE_LIMIT = 100000000;

    typedef struct {
        logic [1:0]              mode;
        logic [COL_W-1:0]        wx;
        logic [ROW_W-1:0]        wy;
        logic                    occ;
        logic signed [CRD_W-1:0] px;
        logic signed [CRD_W-1:0] py;
        logic [CS_W-1:0]         rad;
    } query_t;

    typedef struct {
        logic             pfree;
        logic             in_grid;
        logic [COL_W-1:0] fx;
        logic [ROW_W-1:0] fy;
    } answer_t;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic done;
    logic cfg_wr_en;
    logic [CFG_AW-1:0] cfg_addr;
    logic [CRD_W-1:0] cfg_wdata;
    logic [1:0] mode;
    logic [COL_W-1:0] write_x;
    logic [ROW_W-1:0] write_y;
    logic occupied;
    logic signed [CRD_W-1:0] pos_x;
    logic signed [CRD_W-1:0] pos_y;
    logic [CS_W-1:0] radius;
    logic position_free;
    logic inside_grid;
    logic [COL_W-1:0] found_x;
    logic [ROW_W-1:0] found_y;

    // shadow of the block's map and registers
    bit      blocked_map[MAP_DEPTH];
    longint  grid_ox;
    longint  grid_oy;
    longint  grid_cs;
    longint  grid_w;
    longint  grid_h;
    answer_t pending_answers[$];
    int      mismatches;
    longint  cycles;

    occupancy_grid_clearance_query i_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .done(done),
        .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .mode(mode), .write_x(write_x), .write_y(write_y), .occupied(occupied),
        .pos_x(pos_x), .pos_y(pos_y), .radius(radius),
        .position_free(position_free), .inside_grid(inside_grid),
        .found_x(found_x), .found_y(found_y)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic longint clamp_to(longint v, longint lo, longint hi);
        if (v < lo)
            return lo;
        if (v > hi)
            return hi;
        return v;
    endfunction

    function automatic longint eff_dim(longint v, longint maxv);
        if (v == 0)
            return 1;
        if (v > maxv)
            return maxv;
        return v;
    endfunction

    // applies a cell write to the shadow map and returns the answer expected
    function automatic answer_t predict_clearance(query_t q);
        answer_t a;
        longint  cs, w, h, endx, endy, px, py, r;
        longint  x0, y0, x1, y1, coy, cox, dx, dy;
        bit      any_cell, hit;
        a = '{default: '0};
        cs = (grid_cs == 0) ? 1 : grid_cs;
        w = eff_dim(grid_w, MAX_COLUMNS);
        h = eff_dim(grid_h, MAX_ROWS);
        endx = grid_ox + w * cs;
        endy = grid_oy + h * cs;
        px = longint'(q.px);
        py = longint'(q.py);
        r = longint'(q.rad);
        if (q.mode == MODE_WRITE)
        begin
            blocked_map[int'(q.wy) * MAX_COLUMNS + int'(q.wx)] = q.occ;
        end
        else if (q.mode == MODE_POINT || q.mode == MODE_CIRCLE)
        begin
            if (px >= grid_ox && py >= grid_oy && px < endx && py < endy)
            begin
                a.in_grid = 1'b1;
                a.fx = COL_W'((px - grid_ox) / cs);
                a.fy = ROW_W'((py - grid_oy) / cs);
                if (q.mode == MODE_POINT)
                    a.pfree = !blocked_map[int'((py - grid_oy) / cs) * MAX_COLUMNS
                                           + int'((px - grid_ox) / cs)];
            end
            if (q.mode == MODE_CIRCLE)
            begin
                x0 = (clamp_to(px - r, grid_ox, endx - 1) - grid_ox) / cs;
                y0 = (clamp_to(py - r, grid_oy, endy - 1) - grid_oy) / cs;
                x1 = (clamp_to(px + r, grid_ox, endx - 1) - grid_ox) / cs;
                y1 = (clamp_to(py + r, grid_oy, endy - 1) - grid_oy) / cs;
                any_cell = 0;
                hit = 0;
                for (longint y = y0; y <= y1; y++)
                begin
                    coy = grid_oy + y * cs;
                    dy = clamp_to(py, coy, coy + cs - 1) - py;
                    for (longint x = x0; x <= x1; x++)
                    begin
                        cox = grid_ox + x * cs;
                        dx = clamp_to(px, cox, cox + cs - 1) - px;
                        if (dx * dx + dy * dy < r * r)
                        begin
                            any_cell = 1;
                            if (blocked_map[int'(y) * MAX_COLUMNS + int'(x)])
                                hit = 1;
                        end
                    end
                end
                a.pfree = any_cell && !hit;
            end
        end
        return a;
    endfunction

    // result checker: the block cannot be stalled, so every done cycle is a transaction
    always @(posedge clk)
    begin
        answer_t exp_a;
        if (rst_n && done)
        begin
            if (pending_answers.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result at cycle %0d", cycles);
            end
            else
            begin
                exp_a = pending_answers.pop_front();
                if (position_free !== exp_a.pfree || inside_grid !== exp_a.in_grid ||
                    found_x !== exp_a.fx || found_y !== exp_a.fy)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch cycle %0d: exp free=%0b in=%0b x=%0d y=%0d,",
                                  " got free=%0b in=%0b x=%0d y=%0d"},
                                 cycles, exp_a.pfree, exp_a.in_grid, exp_a.fx, exp_a.fy,
                                 position_free, inside_grid, found_x, found_y);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // drives one transaction and returns at the edge that accepts it; start stays high
    task automatic send_query(query_t q);
        start <= 1'b1;
        mode <= q.mode;
        write_x <= q.wx;
        write_y <= q.wy;
        occupied <= q.occ;
        pos_x <= q.px;
        pos_y <= q.py;
        radius <= q.rad;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_answers.push_back(predict_clearance(q));
    endtask

    task automatic sender_gap(int idle_pct);
        if ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        @(posedge clk);
        while (pending_answers.size() != 0 || busy)
            @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_AW-1:0] idx, longint value);
        cfg_wr_en <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= CRD_W'(value);
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_ORIGIN_X:  grid_ox = longint'($signed(CRD_W'(value)));
            REG_ORIGIN_Y:  grid_oy = longint'($signed(CRD_W'(value)));
            REG_CELL_SIZE: grid_cs = value & 'hFFFF;
            REG_GRID_W:    grid_w = value & 'h7F;
            REG_GRID_H:    grid_h = value & 'h7F;
            default: ;
        endcase
    endtask

    task automatic set_grid(longint ox, longint oy, longint cs, longint w, longint h);
        wait_idle();
        write_reg(REG_ORIGIN_X, ox);
        write_reg(REG_ORIGIN_Y, oy);
        write_reg(REG_CELL_SIZE, cs);
        write_reg(REG_GRID_W, w);
        write_reg(REG_GRID_H, h);
    endtask

    function automatic query_t make_query(logic [1:0] m, int wx, int wy, bit occ,
                                          longint px, longint py, longint rad);
        query_t q;
        q.mode = m;
        q.wx = COL_W'(wx);
        q.wy = ROW_W'(wy);
        q.occ = occ;
        q.px = CRD_W'(px);
        q.py = CRD_W'(py);
        q.rad = CS_W'(rad);
        return q;
    endfunction

    task automatic test_directed_cases();
        send_query(make_query(MODE_WRITE, 0, 0, 1, 0, 0, 0));
        send_query(make_query(MODE_WRITE, 63, 63, 1, 0, 0, 0));
        send_query(make_query(MODE_WRITE, 5, 7, 1, 0, 0, 0));
        send_query(make_query(MODE_POINT, 0, 0, 0, 0, 0, 0));
        send_query(make_query(MODE_POINT, 0, 0, 0, 16383, 16383, 0));
        send_query(make_query(MODE_POINT, 0, 0, 0, 300, 300, 0));
        send_query(make_query(MODE_POINT, 0, 0, 0, -1, 10, 0));
        send_query(make_query(MODE_POINT, 0, 0, 0, 16384, 10, 0));
        send_query(make_query(MODE_POINT, 0, 0, 0, -8388608, 8388607, 65535));
        // zero radius never finds a cell
        send_query(make_query(MODE_CIRCLE, 0, 0, 0, 2000, 2000, 0));
        send_query(make_query(MODE_CIRCLE, 0, 0, 0, 2000, 2000, 100));
        send_query(make_query(MODE_CIRCLE, 0, 0, 0, 5 * 256 + 128, 7 * 256 + 128, 1));
        // just touching the blocked cell's edge vs one LSB short of it
        send_query(make_query(MODE_CIRCLE, 0, 0, 0, 4 * 256 + 128, 7 * 256 + 128, 129));
        send_query(make_query(MODE_CIRCLE, 0, 0, 0, 4 * 256 + 128, 7 * 256 + 128, 128));
        // centre outside the grid still walks the clamped box
        send_query(make_query(MODE_CIRCLE, 0, 0, 0, -300, -300, 600));
        send_query(make_query(MODE_CIRCLE, 0, 0, 0, 20000, 20000, 65535));
        send_query(make_query(MODE_RSVD, 63, 63, 1, 8388607, -8388608, 65535));
        send_query(make_query(MODE_WRITE, 5, 7, 0, 0, 0, 0));
        send_query(make_query(MODE_POINT, 0, 0, 0, 5 * 256, 7 * 256, 0));
        send_query(make_query(MODE_WRITE, 63, 63, 0, 0, 0, 0));
        send_query(make_query(MODE_WRITE, 0, 0, 0, 0, 0, 0));
    endtask

    function automatic longint near_coord(longint org, longint span, longint cs);
        if ($urandom_range(9) == 0)
            return longint'($signed(CRD_W'($urandom)));
        return org + longint'($urandom_range(0, int'((span + 4) * cs))) - 2 * cs;
    endfunction

    task automatic test_random_traffic(int count, int idle_pct);
        query_t  q;
        longint  cs, w, h;
        int      pick;
        for (int i = 0; i < count; i++)
        begin
            cs = (grid_cs == 0) ? 1 : grid_cs;
            w = eff_dim(grid_w, MAX_COLUMNS);
            h = eff_dim(grid_h, MAX_ROWS);
            pick = $urandom_range(99);
            q.mode = (pick < 25) ? MODE_WRITE : (pick < 55) ? MODE_POINT :
                     (pick < 96) ? MODE_CIRCLE : MODE_RSVD;
            q.wx = COL_W'($urandom);
            q.wy = ROW_W'($urandom);
            q.occ = ($urandom_range(2) == 0);
            q.px = CRD_W'(near_coord(grid_ox, w, cs));
            q.py = CRD_W'(near_coord(grid_oy, h, cs));
            // wide radii walk the whole box, so keep them rare
            if ($urandom_range(49) == 0)
                q.rad = CS_W'($urandom);
            else
                q.rad = CS_W'(clamp_to(longint'($urandom_range(0, int'(2 * cs))), 0, 65535));
            send_query(q);
            sender_gap(idle_pct);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_addr = '0;
        cfg_wdata = '0;
        mode = MODE_WRITE;
        write_x = '0;
        write_y = '0;
        occupied = 1'b0;
        pos_x = '0;
        pos_y = '0;
        radius = '0;
        mismatches = 0;
        cycles = 0;
        grid_ox = 0;
        grid_oy = 0;
        grid_cs = 256;
        grid_w = 64;
        grid_h = 64;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_cases();
        test_random_traffic(360, 0);
        set_grid(-8388608, -1000, 1, 1, 64);
        test_random_traffic(360, 75);
        set_grid(8388607, 8388607, 65535, 64, 64);
        test_random_traffic(360, 30);
        // zero cell size and zero width, height beyond storage
        set_grid(123, -77, 0, 0, 127);
        test_random_traffic(360, 0);
        set_grid(longint'($signed(CRD_W'($urandom))), longint'($signed(CRD_W'($urandom))),
                 300, 37, 5);
        test_random_traffic(360, 75);

        wait_idle();
        repeat (50) @(posedge clk);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
